// ----- hdl/asfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_pkg: shared types and constants for the ASCII sensor frame scanner
// Holds the frame byte codes, the window and queue sizes, and the record
// that carries the decoded digits of one frame from the front to the back.
// ----------------------------------------------------------------------------
package asfs_pkg;

  // Window geometry and frame lengths.
  localparam int unsigned WINDOW_DEPTH   = 10;
  localparam int unsigned TEMP_FRAME_LEN = 6;
  localparam int unsigned HUM_FRAME_LEN  = 10;
  localparam int unsigned COUNT_W        = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  // Frame byte codes.
  localparam logic [7:0] CHAR_V     = 8'h76;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // Decoded digits of one accepted frame.
  typedef struct packed {
    logic [3:0] temp_d2;
    logic [3:0] temp_d1;
    logic [3:0] temp_d0;
    logic [3:0] hum_d2;
    logic [3:0] hum_d1;
    logic [3:0] hum_d0;
    logic       hum_present;
  } frame_t;

  // Queue status seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- hdl/asfs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_front: byte window and frame detector
// Shifts each accepted byte into a ten-byte window, counts bytes since the
// last frame, tests the window and pushes the digits of a valid frame.
// ----------------------------------------------------------------------------
module asfs_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  input  asfs_pkg::queue_status_t  queue_status,
  output logic                     push,
  output asfs_pkg::frame_t         push_frame
);

  logic [7:0]                   window [asfs_pkg::WINDOW_DEPTH];
  logic [7:0]                   window_next [asfs_pkg::WINDOW_DEPTH];
  logic [asfs_pkg::COUNT_W-1:0] bytes_since_frame;
  logic [asfs_pkg::COUNT_W-1:0] count_inc;
  logic                         humidity_mode;
  logic                         accept;
  logic                         temp_match;
  logic                         hum_match;
  logic                         long_enough;
  logic                         match;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= asfs_pkg::CHAR_ZERO) && (c <= asfs_pkg::CHAR_NINE);
  endfunction

  // A new byte is taken whenever the queue has room for a possible frame.
  assign in_ready = !queue_status.full;
  assign accept   = in_valid && in_ready;

  // The window as it stands after the incoming byte; entry nine is newest.
  always_comb begin
    for (int i = 0; i < asfs_pkg::WINDOW_DEPTH - 1; i++) begin
      window_next[i] = window[i+1];
    end
    window_next[asfs_pkg::WINDOW_DEPTH-1] = rx_byte;
  end

  // The count saturates so that testing continues on every byte.
  assign count_inc = (bytes_since_frame == asfs_pkg::COUNT_MAX) ?
                     asfs_pkg::COUNT_MAX : bytes_since_frame + 1'b1;

  // Frame tests on the newest six or ten bytes.
  assign temp_match = (window_next[4] == asfs_pkg::CHAR_V) &&
                      (window_next[5] == asfs_pkg::CHAR_SPACE) &&
                      is_digit(window_next[6]) && is_digit(window_next[7]) &&
                      is_digit(window_next[8]) &&
                      (window_next[9] == asfs_pkg::CHAR_CR);

  assign hum_match = (window_next[0] == asfs_pkg::CHAR_V) &&
                     (window_next[1] == asfs_pkg::CHAR_SPACE) &&
                     is_digit(window_next[2]) && is_digit(window_next[3]) &&
                     is_digit(window_next[4]) &&
                     (window_next[5] == asfs_pkg::CHAR_SPACE) &&
                     is_digit(window_next[6]) && is_digit(window_next[7]) &&
                     is_digit(window_next[8]) &&
                     (window_next[9] == asfs_pkg::CHAR_CR);

  assign long_enough = humidity_mode ?
      (count_inc >= asfs_pkg::COUNT_W'(asfs_pkg::HUM_FRAME_LEN)) :
      (count_inc >= asfs_pkg::COUNT_W'(asfs_pkg::TEMP_FRAME_LEN));

  assign match = long_enough && (humidity_mode ? hum_match : temp_match);
  assign push  = accept && match;

  // Digit values are the low nibble of an ASCII digit.
  always_comb begin
    if (humidity_mode) begin
      push_frame.temp_d2     = window_next[2][3:0];
      push_frame.temp_d1     = window_next[3][3:0];
      push_frame.temp_d0     = window_next[4][3:0];
      push_frame.hum_d2      = window_next[6][3:0];
      push_frame.hum_d1      = window_next[7][3:0];
      push_frame.hum_d0      = window_next[8][3:0];
      push_frame.hum_present = 1'b1;
    end else begin
      push_frame.temp_d2     = window_next[6][3:0];
      push_frame.temp_d1     = window_next[7][3:0];
      push_frame.temp_d0     = window_next[8][3:0];
      push_frame.hum_d2      = 4'd0;
      push_frame.hum_d1      = 4'd0;
      push_frame.hum_d0      = 4'd0;
      push_frame.hum_present = 1'b0;
    end
  end

  // Mode register, window and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      humidity_mode     <= 1'b0;
      bytes_since_frame <= '0;
      for (int i = 0; i < asfs_pkg::WINDOW_DEPTH; i++) begin
        window[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        humidity_mode <= cfg_wdata;
      end
      if (accept) begin
        window            <= window_next;
        bytes_since_frame <= match ? '0 : count_inc;
      end
    end
  end

endmodule

// ----- hdl/asfs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_queue: short frame queue
// Holds detected frames between the detector and the value builder so that
// either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module asfs_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  asfs_pkg::frame_t         push_frame,
  input  logic                     pop,
  output asfs_pkg::frame_t         head_frame,
  output asfs_pkg::queue_status_t  status
);

  asfs_pkg::frame_t                 entries [asfs_pkg::QUEUE_DEPTH];
  logic [asfs_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [asfs_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [asfs_pkg::QUEUE_CNT_W-1:0] fill;

  assign status.full  = (fill == asfs_pkg::QUEUE_CNT_W'(asfs_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign head_frame   = entries[rd_ptr];

  // Storage needs no reset; only written entries are ever read.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/asfs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_back: value builder and output register
// Pops a frame, turns its three-digit groups into values in tenths and
// holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module asfs_back (
  input  logic                     clk,
  input  logic                     rst,
  input  asfs_pkg::queue_status_t  queue_status,
  input  asfs_pkg::frame_t         head_frame,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [9:0]               temperature_tenths,
  output logic [9:0]               humidity_tenths,
  output logic                     humidity_present
);

  logic [9:0] temp_value;
  logic [9:0] hum_value;

  function automatic logic [9:0] digits_to_value(input logic [3:0] d2,
                                                 input logic [3:0] d1,
                                                 input logic [3:0] d0);
    digits_to_value = ({6'd0, d2} * 10'd100) + ({6'd0, d1} * 10'd10) + {6'd0, d0};
  endfunction

  assign temp_value = digits_to_value(head_frame.temp_d2, head_frame.temp_d1,
                                      head_frame.temp_d0);
  assign hum_value  = digits_to_value(head_frame.hum_d2, head_frame.hum_d1,
                                      head_frame.hum_d0);

  // Load the output register when it is empty or being emptied.
  assign pop = !queue_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      temperature_tenths <= temp_value;
      humidity_tenths    <= hum_value;
      humidity_present   <= head_frame.hum_present;
    end
  end

endmodule

// ----- hdl/ascii_sensor_frame_scanner_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_sensor_frame_scanner_top: ASCII sensor frame scanner
// Scans a byte stream for "v ddd\r" or "v ddd ddd\r" frames and emits the
// digit groups as values in tenths.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   rx_byte
//   output   out_valid / out_ready temperature_tenths, humidity_tenths,
//                                  humidity_present
//   config   cfg_we                cfg_wdata (humidity_mode)
//
// One byte word is taken per cycle while in_ready is high. The frame test
// runs in the same cycle as the window shift; a result word passes through
// the queue and then the output register.
// Reset is synchronous and clears the window, count, mode and queue.
// A stalled output fills the four-entry queue; input stalls only when full.
// ----------------------------------------------------------------------------
module ascii_sensor_frame_scanner_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] temperature_tenths,
  output logic [9:0] humidity_tenths,
  output logic       humidity_present
);

  asfs_pkg::queue_status_t queue_status;
  asfs_pkg::frame_t        push_frame;
  asfs_pkg::frame_t        head_frame;
  logic                    push;
  logic                    pop;

  // Byte window and frame detector.
  asfs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .queue_status (queue_status),
    .push         (push),
    .push_frame   (push_frame)
  );

  // Frame queue.
  asfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .status     (queue_status)
  );

  // Value builder and output register.
  asfs_back u_back (
    .clk                (clk),
    .rst                (rst),
    .queue_status       (queue_status),
    .head_frame         (head_frame),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .temperature_tenths (temperature_tenths),
    .humidity_tenths    (humidity_tenths),
    .humidity_present   (humidity_present)
  );

endmodule
